@@ rtl/trl_pkg.sv @@
// ----------------------------------------------------------------------------
// trl_pkg
// Shared constants and types for the three-anchor trilateration solver.
// ----------------------------------------------------------------------------
package trl_pkg;

    localparam int RANGE_W   = 24;
    localparam int CFG_IDX_W = 3;

    localparam int A1X_RST = 2560;
    localparam int A1Y_RST = 2560;
    localparam int A2X_RST = 2560;
    localparam int A2Y_RST = 1280;
    localparam int A3X_RST = 1280;
    localparam int A3Y_RST = 2560;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A1X = 3'd0,
        CFG_A1Y = 3'd1,
        CFG_A2X = 3'd2,
        CFG_A2Y = 3'd3,
        CFG_A3X = 3'd4,
        CFG_A3Y = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic clip;
    } div_stat_t;

endpackage

@@ rtl/three_anchor_trilateration.sv @@
// ----------------------------------------------------------------------------
// three_anchor_trilateration
// 2D position from three ranges to configured anchors, Cramer's rule on the
// linearized 2x2 system, pipelined end to end.
// ----------------------------------------------------------------------------
// channel   direction  handshake              word
// input     in         start & !busy          range_one, range_two, range_three
// result    out        done (one cycle)       pos_x, pos_y, clipped
// config    in         cfg_we                 cfg_index, cfg_data
//
// One word per cycle; busy stays low. The one-bit-per-stage divider follows
// five stages of squares and products.
// Words with a zero range or collinear anchors give no result.
// Reset clears the anchors to their defaults and empties the pipeline.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module three_anchor_trilateration
    import trl_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [RANGE_W-1:0]            range_one,
    input  logic [RANGE_W-1:0]            range_two,
    input  logic [RANGE_W-1:0]            range_three,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] pos_x,
    output logic signed [COORD_WIDTH-1:0] pos_y,
    output logic                          clipped
);

    localparam int W   = COORD_WIDTH;
    localparam int MW  = (W > RANGE_W) ? W : RANGE_W;
    localparam int SQW = 2 * RANGE_W;
    localparam int ASW = 2 * W;
    localparam int CW  = 2 * MW + 2;
    localparam int EW  = W + 2;
    localparam int CL  = CW / 2;
    localparam int CH  = CW - CL;
    localparam int PLW = CL + 1 + EW;
    localparam int PHW = CH + EW;
    localparam int PW  = CW + EW;
    localparam int NW  = PW + 1;
    localparam int DTW = 2 * EW + 1;
    localparam int LAT = W + 9;

    logic signed [W-1:0] anchor1_x_reg, anchor1_y_reg, anchor2_x_reg;
    logic signed [W-1:0] anchor2_y_reg, anchor3_x_reg, anchor3_y_reg;

    logic signed [EW-1:0]  coef_a_reg, coef_b_reg, coef_d_reg, coef_e_reg;
    logic signed [ASW-1:0] asq_x1_reg, asq_y1_reg, asq_x2_reg;
    logic signed [ASW-1:0] asq_y2_reg, asq_x3_reg, asq_y3_reg;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [SQW-1:0]        rsq1_reg, rsq2_reg, rsq3_reg;
    logic signed [CW-1:0]  c_reg, f_reg;
    logic signed [CW-1:0]  c_next, f_next;

    logic signed [PLW-1:0] ce_lo_reg, fb_lo_reg, af_lo_reg, cd_lo_reg;
    logic signed [PHW-1:0] ce_hi_reg, fb_hi_reg, af_hi_reg, cd_hi_reg;
    logic signed [2*EW-1:0] ae_reg, bd_reg;

    logic signed [PW-1:0]  ce_reg, fb_reg, af_reg, cd_reg;
    logic signed [DTW-1:0] det4_reg, det5_reg;
    logic signed [NW-1:0]  nx_reg, ny_reg;

    div_stat_t stat_x, stat_y;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor1_x_reg <= W'(A1X_RST);
            anchor1_y_reg <= W'(A1Y_RST);
            anchor2_x_reg <= W'(A2X_RST);
            anchor2_y_reg <= W'(A2Y_RST);
            anchor3_x_reg <= W'(A3X_RST);
            anchor3_y_reg <= W'(A3Y_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_A1X: anchor1_x_reg <= cfg_data;
                CFG_A1Y: anchor1_y_reg <= cfg_data;
                CFG_A2X: anchor2_x_reg <= cfg_data;
                CFG_A2Y: anchor2_y_reg <= cfg_data;
                CFG_A3X: anchor3_x_reg <= cfg_data;
                CFG_A3Y: anchor3_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // geometry terms, refreshed every cycle from the anchors
    always_ff @(posedge clk)
    begin
        coef_a_reg <= (EW'(anchor2_x_reg) - EW'(anchor1_x_reg)) <<< 1;
        coef_b_reg <= (EW'(anchor2_y_reg) - EW'(anchor1_y_reg)) <<< 1;
        coef_d_reg <= (EW'(anchor3_x_reg) - EW'(anchor2_x_reg)) <<< 1;
        coef_e_reg <= (EW'(anchor3_y_reg) - EW'(anchor2_y_reg)) <<< 1;
        asq_x1_reg <= ASW'(anchor1_x_reg) * ASW'(anchor1_x_reg);
        asq_y1_reg <= ASW'(anchor1_y_reg) * ASW'(anchor1_y_reg);
        asq_x2_reg <= ASW'(anchor2_x_reg) * ASW'(anchor2_x_reg);
        asq_y2_reg <= ASW'(anchor2_y_reg) * ASW'(anchor2_y_reg);
        asq_x3_reg <= ASW'(anchor3_x_reg) * ASW'(anchor3_x_reg);
        asq_y3_reg <= ASW'(anchor3_y_reg) * ASW'(anchor3_y_reg);
    end

    assign c_next = $signed(CW'(rsq1_reg)) - $signed(CW'(rsq2_reg))
                  - CW'(asq_x1_reg) + CW'(asq_x2_reg)
                  - CW'(asq_y1_reg) + CW'(asq_y2_reg);
    assign f_next = $signed(CW'(rsq2_reg)) - $signed(CW'(rsq3_reg))
                  - CW'(asq_x2_reg) + CW'(asq_x3_reg)
                  - CW'(asq_y2_reg) + CW'(asq_y3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && (range_one != '0) && (range_two != '0)
                      && (range_three != '0);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg && (det4_reg != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        // squares of the ranges
        rsq1_reg <= SQW'(range_one) * SQW'(range_one);
        rsq2_reg <= SQW'(range_two) * SQW'(range_two);
        rsq3_reg <= SQW'(range_three) * SQW'(range_three);

        // right-hand sides
        c_reg <= c_next;
        f_reg <= f_next;

        // partial products, C and F split in halves
        ce_lo_reg <= PLW'($signed({1'b0, c_reg[CL-1:0]})) * PLW'(coef_e_reg);
        ce_hi_reg <= PHW'($signed(c_reg[CW-1:CL])) * PHW'(coef_e_reg);
        fb_lo_reg <= PLW'($signed({1'b0, f_reg[CL-1:0]})) * PLW'(coef_b_reg);
        fb_hi_reg <= PHW'($signed(f_reg[CW-1:CL])) * PHW'(coef_b_reg);
        af_lo_reg <= PLW'($signed({1'b0, f_reg[CL-1:0]})) * PLW'(coef_a_reg);
        af_hi_reg <= PHW'($signed(f_reg[CW-1:CL])) * PHW'(coef_a_reg);
        cd_lo_reg <= PLW'($signed({1'b0, c_reg[CL-1:0]})) * PLW'(coef_d_reg);
        cd_hi_reg <= PHW'($signed(c_reg[CW-1:CL])) * PHW'(coef_d_reg);
        ae_reg    <= (2*EW)'(coef_a_reg) * (2*EW)'(coef_e_reg);
        bd_reg    <= (2*EW)'(coef_b_reg) * (2*EW)'(coef_d_reg);

        // recombine
        ce_reg   <= $signed({ce_hi_reg, {CL{1'b0}}}) + PW'(ce_lo_reg);
        fb_reg   <= $signed({fb_hi_reg, {CL{1'b0}}}) + PW'(fb_lo_reg);
        af_reg   <= $signed({af_hi_reg, {CL{1'b0}}}) + PW'(af_lo_reg);
        cd_reg   <= $signed({cd_hi_reg, {CL{1'b0}}}) + PW'(cd_lo_reg);
        det4_reg <= DTW'(ae_reg) - DTW'(bd_reg);

        // Cramer numerators
        nx_reg   <= NW'(ce_reg) - NW'(fb_reg);
        ny_reg   <= NW'(af_reg) - NW'(cd_reg);
        det5_reg <= det4_reg;
    end

    trl_div #(
        .NW (NW),
        .DW (DTW),
        .QW (W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v5_reg),
        .num      (nx_reg),
        .den      (det5_reg),
        .quot     (pos_x),
        .stat     (stat_x)
    );

    trl_div #(
        .NW (NW),
        .DW (DTW),
        .QW (W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v5_reg),
        .num      (ny_reg),
        .den      (det5_reg),
        .quot     (pos_y),
        .stat     (stat_y)
    );

    assign done    = stat_x.valid;
    assign clipped = stat_x.valid & (stat_x.clip | stat_y.clip);

    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        stat_x.valid == stat_y.valid)
        else $error("x and y dividers out of step");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a word accepted LAT cycles earlier");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(range_one, LAT) != '0) && ($past(range_two, LAT) != '0)
                 && ($past(range_three, LAT) != '0))
        else $error("result from a word with a zero range");

endmodule

@@ rtl/trl_div.sv @@
// ----------------------------------------------------------------------------
// trl_div
// Pipelined signed divider, one quotient bit per stage, rounded to nearest
// (ties away from zero) and saturated to a QW-bit signed result.
// ----------------------------------------------------------------------------
module trl_div
    import trl_pkg::*;
#(
    parameter int NW = 77,
    parameter int DW = 53,
    parameter int QW = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic signed [QW-1:0] quot,
    output div_stat_t            stat
);

    localparam int SN = QW + 2;
    localparam int FI = QW + 1;

    logic          v0_reg;
    logic [NW-1:0] nabs_reg;
    logic [DW-1:0] dabs_reg;
    logic          neg0_reg;

    logic [NW-1:0] nabs_next;
    logic [DW-1:0] dabs_next;
    logic [NW-1:0] head;

    logic          v_reg   [SN];
    logic [DW-1:0] rem_reg [SN];
    logic [QW:0]   q_reg   [SN];
    logic [QW:0]   lo_reg  [SN];
    logic [DW-1:0] d_reg   [SN];
    logic          neg_reg [SN];
    logic          ovf_reg [SN];

    logic          rnd;
    logic [QW+1:0] qr;
    logic [QW+1:0] lim;
    logic          sat;
    logic [QW+1:0] mag;
    logic [QW+1:0] res;
    logic          clip_reg;
    logic          vout_reg;

    assign nabs_next = num[NW-1] ? -num : num;
    assign dabs_next = den[DW-1] ? -den : den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nabs_reg <= nabs_next;
        dabs_reg <= dabs_next;
        neg0_reg <= num[NW-1] ^ den[DW-1];
    end

    // head stage: overflow test and initial remainder
    assign head = nabs_reg >> (QW + 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= DW'(head);
        q_reg[0]   <= '0;
        lo_reg[0]  <= nabs_reg[QW:0];
        d_reg[0]   <= dabs_reg;
        neg_reg[0] <= neg0_reg;
        ovf_reg[0] <= head >= NW'(dabs_reg);
    end

    for (genvar k = 0; k <= QW; k++)
    begin : g_step
        logic [DW:0] shl;
        logic [DW:0] dif;
        logic        take;

        assign shl  = {rem_reg[k], lo_reg[k][QW-k]};
        assign dif  = shl - {1'b0, d_reg[k]};
        assign take = shl >= {1'b0, d_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= take ? dif[DW-1:0] : shl[DW-1:0];
            q_reg[k+1]   <= {q_reg[k][QW-1:0], take};
            lo_reg[k+1]  <= lo_reg[k];
            d_reg[k+1]   <= d_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    // rounding and saturation
    assign rnd = {rem_reg[FI], 1'b0} >= {1'b0, d_reg[FI]};
    assign qr  = (QW+2)'(q_reg[FI]) + (QW+2)'(rnd);
    assign lim = ((QW+2)'(1) << (QW - 1)) - (QW+2)'(!neg_reg[FI]);
    assign sat = ovf_reg[FI] || (qr > lim);
    assign mag = sat ? lim : qr;
    assign res = neg_reg[FI] ? -mag : mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else
        begin
            vout_reg <= v_reg[FI];
        end
    end

    always_ff @(posedge clk)
    begin
        quot     <= res[QW-1:0];
        clip_reg <= sat;
    end

    assign stat.valid = vout_reg;
    assign stat.clip  = clip_reg;

endmodule

@@ tb/sv/tb_three_anchor_trilateration.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_anchor_trilateration
// Drives range words through the solver under several anchor layouts
// (reset default, extreme corners, collinear, random) and checks each result
// word against an exact wide-integer Cramer's rule model kept here.
// ----------------------------------------------------------------------------
module tb_three_anchor_trilateration;
    import trl_pkg::*;

    localparam int CW        = 24;
    localparam int LATENCY   = CW + 9;
    localparam int MAX_CYC   = 400000;
    localparam int PHASE_LEN = 270;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 clip;
    } fix_t;

    typedef struct {
        logic [RANGE_W-1:0] r1;
        logic [RANGE_W-1:0] r2;
        logic [RANGE_W-1:0] r3;
        bit                 silent;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [RANGE_W-1:0]   range_one;
    logic [RANGE_W-1:0]   range_two;
    logic [RANGE_W-1:0]   range_three;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CW-1:0]        cfg_data;
    logic                 done;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic                 clipped;

    logic signed [CW-1:0] anchor [6];
    fix_t                 fix_q [$];
    int                   n_err = 0;
    int                   n_cyc = 0;

    three_anchor_trilateration #(.COORD_WIDTH(CW)) uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        n_err++;
    endtask

    function automatic logic signed [CW-1:0] div_round(input logic signed [127:0] num,
        input logic signed [127:0] den, inout logic clip);
        logic [127:0] n, d, q, r, lim;
        bit           neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n % d;
        if ((r << 1) >= d)
            q = q + 1;
        lim = neg ? (128'd1 << (CW - 1)) : ((128'd1 << (CW - 1)) - 1);
        if (q > lim)
        begin
            q = lim;
            clip = 1'b1;
        end
        return neg ? -q[CW-1:0] : q[CW-1:0];
    endfunction

    // returns 0 when the word gives no fix
    function automatic bit solve_fix(input logic [RANGE_W-1:0] r1, r2, r3, output fix_t fx);
        logic signed [127:0] x1, y1, x2, y2, x3, y3, s1, s2, s3;
        logic signed [127:0] a, b, c, d, e, f, det;
        fx.clip = 1'b0;
        fx.x = '0;
        fx.y = '0;
        if (r1 == 0 || r2 == 0 || r3 == 0)
            return 0;
        x1 = 128'(anchor[CFG_A1X]); y1 = 128'(anchor[CFG_A1Y]);
        x2 = 128'(anchor[CFG_A2X]); y2 = 128'(anchor[CFG_A2Y]);
        x3 = 128'(anchor[CFG_A3X]); y3 = 128'(anchor[CFG_A3Y]);
        s1 = $signed({104'd0, r1}) * $signed({104'd0, r1});
        s2 = $signed({104'd0, r2}) * $signed({104'd0, r2});
        s3 = $signed({104'd0, r3}) * $signed({104'd0, r3});
        a = 2 * (x2 - x1);
        b = 2 * (y2 - y1);
        d = 2 * (x3 - x2);
        e = 2 * (y3 - y2);
        c = s1 - s2 - x1 * x1 + x2 * x2 - y1 * y1 + y2 * y2;
        f = s2 - s3 - x2 * x2 + x3 * x3 - y2 * y2 + y3 * y3;
        det = a * e - b * d;
        if (det == 0)
            return 0;
        fx.x = div_round(c * e - f * b, det, fx.clip);
        fx.y = div_round(a * f - c * d, det, fx.clip);
        return 1;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (fix_q.size() == 0)
                report_mismatch("unexpected word", int'(pos_x), 0);
            else
            begin
                fix_t w;
                w = fix_q.pop_front();
                if (pos_x !== w.x)
                    report_mismatch("pos_x", int'(pos_x), int'(w.x));
                if (pos_y !== w.y)
                    report_mismatch("pos_y", int'(pos_y), int'(w.y));
                if (clipped !== w.clip)
                    report_mismatch("clipped", int'(clipped), int'(w.clip));
            end
        end
    end

    always @(posedge clk)
    begin
        n_cyc <= n_cyc + 1;
        if (n_cyc > MAX_CYC)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(input logic [RANGE_W-1:0] r1, r2, r3);
        fix_t fx;
        if (solve_fix(r1, r2, r3, fx))
            fix_q.push_back(fx);
        start       <= 1'b1;
        range_one   <= r1;
        range_two   <= r2;
        range_three <= r3;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (fix_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic load_anchors(input logic signed [CW-1:0] v [6]);
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= v[i];
            anchor[i] = v[i];
            @(posedge clk);
        end
        // spare index must leave the anchors alone
        cfg_index <= CFG_SPARE;
        cfg_data  <= CW'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_words(input int count);
        int   burst;
        int   k;
        int   pick;
        real  px, py, d1, d2, d3;
        logic [RANGE_W-1:0] r [3];
        k = 0;
        while (k < count)
        begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && k < count; j++, k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    px = (anchor[CFG_A1X] + anchor[CFG_A3X]) / 2.0
                        + $itor($signed($urandom_range(0, 8192)) - 4096) * 4.0;
                    py = (anchor[CFG_A1Y] + anchor[CFG_A2Y]) / 2.0
                        + $itor($signed($urandom_range(0, 8192)) - 4096) * 4.0;
                    d1 = $sqrt((px - anchor[CFG_A1X]) ** 2 + (py - anchor[CFG_A1Y]) ** 2);
                    d2 = $sqrt((px - anchor[CFG_A2X]) ** 2 + (py - anchor[CFG_A2Y]) ** 2);
                    d3 = $sqrt((px - anchor[CFG_A3X]) ** 2 + (py - anchor[CFG_A3Y]) ** 2);
                    r[0] = (d1 >= 16777215.0) ? 24'hFFFFFF : ((d1 < 1.0) ? 24'd1 : RANGE_W'(longint'(d1)));
                    r[1] = (d2 >= 16777215.0) ? 24'hFFFFFF : ((d2 < 1.0) ? 24'd1 : RANGE_W'(longint'(d2)));
                    r[2] = (d3 >= 16777215.0) ? 24'hFFFFFF : ((d3 < 1.0) ? 24'd1 : RANGE_W'(longint'(d3)));
                end
                else if (pick < 85)
                begin
                    for (int i = 0; i < 3; i++)
                        r[i] = RANGE_W'($urandom);
                end
                else if (pick < 95)
                begin
                    for (int i = 0; i < 3; i++)
                        r[i] = RANGE_W'($urandom_range(1, 4096));
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        r[i] = RANGE_W'($urandom);
                    r[$urandom_range(0, 2)] = '0;
                end
                send_word(r[0], r[1], r[2]);
            end
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 6));
        end
    endtask

    dir_row_t dir_tab [] = '{
        '{24'd1,      24'd1,      24'd1,      1'b0},
        '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0},
        '{24'hFFFFFF, 24'd1,      24'd1,      1'b0},
        '{24'd1,      24'hFFFFFF, 24'd1,      1'b0},
        '{24'd1,      24'd1,      24'hFFFFFF, 1'b0},
        '{24'd0,      24'd1280,   24'd1280,   1'b1},
        '{24'd1280,   24'd0,      24'd1280,   1'b1},
        '{24'd1280,   24'd1280,   24'd0,      1'b1},
        '{24'd0,      24'd0,      24'd0,      1'b1},
        '{24'd724,    24'd1280,   24'd1280,   1'b0},
        '{24'd1086,   24'd1280,   24'd724,    1'b0},
        '{24'h800000, 24'h000001, 24'h7FFFFF, 1'b0},
        '{24'h555555, 24'hAAAAAA, 24'h555555, 1'b0}
    };

    initial
    begin
        logic signed [CW-1:0] lay [6];
        rst_n       = 1'b0;
        start       = 1'b0;
        range_one   = '0;
        range_two   = '0;
        range_three = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_A1X;
        cfg_data    = '0;
        anchor[CFG_A1X] = CW'(A1X_RST); anchor[CFG_A1Y] = CW'(A1Y_RST);
        anchor[CFG_A2X] = CW'(A2X_RST); anchor[CFG_A2Y] = CW'(A2Y_RST);
        anchor[CFG_A3X] = CW'(A3X_RST); anchor[CFG_A3Y] = CW'(A3Y_RST);
        repeat (3) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset layout, table first
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].silent)
            begin
                start       <= 1'b1;
                range_one   <= dir_tab[i].r1;
                range_two   <= dir_tab[i].r2;
                range_three <= dir_tab[i].r3;
                @(posedge clk);
                while (busy)
                    @(posedge clk);
            end
            else
                send_word(dir_tab[i].r1, dir_tab[i].r2, dir_tab[i].r3);
        end
        random_words(PHASE_LEN);
        drain();

        // extreme corners
        lay = '{24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, -24'sh800000, -24'sh800000};
        load_anchors(lay);
        send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_word(24'd1, 24'd1, 24'd1);
        random_words(PHASE_LEN);
        drain();

        // collinear anchors: nothing comes out
        lay = '{24'sd0, 24'sd0, 24'sd256, 24'sd256, 24'sd512, 24'sd512};
        load_anchors(lay);
        random_words(60);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            for (int i = 0; i < 6; i++)
                lay[i] = (p == 0) ? CW'($urandom) : CW'($signed($urandom_range(0, 40000)) - 20000);
            load_anchors(lay);
            random_words(PHASE_LEN);
            drain();
        end

        if (n_err == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
